// ----- hw/rtl/rv32id_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32id_pkg - RV32I decoder shared types and codes
// Beat structs, opcode values and the output code points used by the decoder.
// ----------------------------------------------------------------------------
package rv32id_pkg;

	// command beat
	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] pc;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic        illegal;
		logic [3:0]  opcode_class;
		logic [4:0]  dest_reg;
		logic [4:0]  src1_reg;
		logic [4:0]  src2_reg;
		logic [31:0] immediate;
		logic [9:0]  funct_bits;
		logic [3:0]  alu_sel;
		logic [3:0]  branch_sel;
		logic [1:0]  unit_sel;
		logic [12:0] ctrl_flags;
		logic [31:0] pc_out;
	} rsp_t;

	// major opcodes
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_FENCE  = 7'h0f;

	// opcode classes
	localparam logic [3:0] CLS_R      = 4'd0;
	localparam logic [3:0] CLS_LOAD   = 4'd1;
	localparam logic [3:0] CLS_OPIMM  = 4'd2;
	localparam logic [3:0] CLS_STORE  = 4'd3;
	localparam logic [3:0] CLS_BRANCH = 4'd4;
	localparam logic [3:0] CLS_LUI    = 4'd5;
	localparam logic [3:0] CLS_AUIPC  = 4'd6;
	localparam logic [3:0] CLS_JAL    = 4'd7;
	localparam logic [3:0] CLS_JALR   = 4'd8;
	localparam logic [3:0] CLS_SYSTEM = 4'd9;
	localparam logic [3:0] CLS_FENCE  = 4'd10;

	// ALU operations
	localparam logic [3:0] ALU_NONE = 4'd0;
	localparam logic [3:0] ALU_ADD  = 4'd1;
	localparam logic [3:0] ALU_SUB  = 4'd2;
	localparam logic [3:0] ALU_SLL  = 4'd3;
	localparam logic [3:0] ALU_SLT  = 4'd4;
	localparam logic [3:0] ALU_SLTU = 4'd5;
	localparam logic [3:0] ALU_XOR  = 4'd6;
	localparam logic [3:0] ALU_SRL  = 4'd7;
	localparam logic [3:0] ALU_SRA  = 4'd8;
	localparam logic [3:0] ALU_OR   = 4'd9;
	localparam logic [3:0] ALU_AND  = 4'd10;

	// branch operations
	localparam logic [3:0] BR_NONE = 4'd0;
	localparam logic [3:0] BR_BEQ  = 4'd1;
	localparam logic [3:0] BR_BNE  = 4'd2;
	localparam logic [3:0] BR_BLT  = 4'd3;
	localparam logic [3:0] BR_BGE  = 4'd4;
	localparam logic [3:0] BR_BLTU = 4'd5;
	localparam logic [3:0] BR_BGEU = 4'd6;
	localparam logic [3:0] BR_JAL  = 4'd7;
	localparam logic [3:0] BR_JALR = 4'd8;

	// functional units
	localparam logic [1:0] UNIT_ALU = 2'd0;
	localparam logic [1:0] UNIT_LSU = 2'd1;
	localparam logic [1:0] UNIT_SFU = 2'd2;
	localparam logic [1:0] UNIT_BRU = 2'd3;

	// ctrl_flags bit positions
	localparam int FL_RD    = 0;
	localparam int FL_RS1   = 1;
	localparam int FL_RS2   = 2;
	localparam int FL_IMM   = 3;
	localparam int FL_S2IMM = 4;
	localparam int FL_S1PC  = 5;
	localparam int FL_S1INV = 6;
	localparam int FL_S1RS1 = 7;
	localparam int FL_S2CSR = 8;
	localparam int FL_LOAD  = 9;
	localparam int FL_STORE = 10;
	localparam int FL_CSR   = 11;
	localparam int FL_EXIT  = 12;

	// SYSTEM funct3 0 immediates
	localparam logic [11:0] SYS_ECALL  = 12'h000;
	localparam logic [11:0] SYS_EBREAK = 12'h001;
	localparam logic [11:0] SYS_URET   = 12'h002;
	localparam logic [11:0] SYS_SRET   = 12'h102;
	localparam logic [11:0] SYS_MRET   = 12'h302;

endpackage

// ----- hw/rtl/rv32id_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32id_decode - RV32I field and control decode
// Combinational decode of one instruction word into the result beat.
// ----------------------------------------------------------------------------
module rv32id_decode
	import rv32id_pkg::*;
(
	input  cmd_t cmd,
	output rsp_t rsp
);

	logic [31:0] w;
	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [6:0]  f7;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_u;
	logic [31:0] imm_j;

	logic [31:0] imm;
	logic [12:0] fl;
	logic [3:0]  alu;
	logic [3:0]  br;
	logic [3:0]  cls;
	logic [1:0]  unit;
	logic        bad;

	assign w     = cmd.instr_word;
	assign opc   = w[6:0];
	assign rd    = w[11:7];
	assign f3    = w[14:12];
	assign rs1   = w[19:15];
	assign rs2   = w[24:20];
	assign f7    = w[31:25];
	assign imm_i = {{20{w[31]}}, w[31:20]};
	assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
	assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
	assign imm_u = {w[31:12], 12'h000};
	assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

	always_comb begin
		imm = '0;
		fl  = '0;
		alu = ALU_NONE;
		br  = BR_NONE;
		cls = CLS_R;
		bad = 1'b0;
		unique case (opc)
			OPC_OP: begin
				cls = CLS_R;
				fl[FL_RD] = 1'b1; fl[FL_RS1] = 1'b1; fl[FL_RS2] = 1'b1;
			end
			OPC_LOAD: begin
				cls = CLS_LOAD;
				fl[FL_RD] = 1'b1; fl[FL_RS1] = 1'b1; fl[FL_IMM] = 1'b1;
				fl[FL_S2IMM] = 1'b1; fl[FL_LOAD] = 1'b1;
				imm = imm_i; alu = ALU_ADD;
			end
			OPC_OPIMM: begin
				cls = CLS_OPIMM;
				fl[FL_RD] = 1'b1; fl[FL_RS1] = 1'b1; fl[FL_IMM] = 1'b1;
				fl[FL_S2IMM] = 1'b1;
				// shifts carry shamt only
				imm = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, rs2} : imm_i;
			end
			OPC_STORE: begin
				cls = CLS_STORE;
				fl[FL_RS1] = 1'b1; fl[FL_RS2] = 1'b1; fl[FL_IMM] = 1'b1;
				fl[FL_S2IMM] = 1'b1; fl[FL_STORE] = 1'b1;
				imm = imm_s; alu = ALU_ADD;
			end
			OPC_BRANCH: begin
				cls = CLS_BRANCH;
				fl[FL_RS1] = 1'b1; fl[FL_RS2] = 1'b1; fl[FL_IMM] = 1'b1;
				fl[FL_S2IMM] = 1'b1; fl[FL_S1PC] = 1'b1;
				imm = imm_b; alu = ALU_ADD;
				unique case (f3)
					3'd0:    br = BR_BEQ;
					3'd1:    br = BR_BNE;
					3'd4:    br = BR_BLT;
					3'd5:    br = BR_BGE;
					3'd6:    br = BR_BLTU;
					3'd7:    br = BR_BGEU;
					default: bad = 1'b1;
				endcase
			end
			OPC_LUI: begin
				cls = CLS_LUI;
				fl[FL_RD] = 1'b1; fl[FL_IMM] = 1'b1; fl[FL_S2IMM] = 1'b1;
				imm = imm_u; alu = ALU_ADD;
			end
			OPC_AUIPC: begin
				cls = CLS_AUIPC;
				fl[FL_RD] = 1'b1; fl[FL_IMM] = 1'b1; fl[FL_S2IMM] = 1'b1;
				fl[FL_S1PC] = 1'b1;
				imm = imm_u; alu = ALU_ADD;
			end
			OPC_JAL: begin
				cls = CLS_JAL;
				fl[FL_RD] = 1'b1; fl[FL_IMM] = 1'b1; fl[FL_S2IMM] = 1'b1;
				fl[FL_S1PC] = 1'b1;
				imm = imm_j; alu = ALU_ADD; br = BR_JAL;
			end
			OPC_JALR: begin
				cls = CLS_JALR;
				fl[FL_RD] = 1'b1; fl[FL_RS1] = 1'b1; fl[FL_IMM] = 1'b1;
				fl[FL_S2IMM] = 1'b1;
				imm = imm_i; alu = ALU_ADD; br = BR_JALR;
			end
			OPC_SYSTEM: begin
				cls = CLS_SYSTEM;
				fl[FL_IMM] = 1'b1;
				imm = {20'd0, w[31:20]};
				if (f3 == 3'd0) begin
					alu = ALU_ADD;
					if (w[31:20] == SYS_ECALL || w[31:20] == SYS_EBREAK) begin
						fl[FL_EXIT] = 1'b1;
					end else if (w[31:20] != SYS_URET && w[31:20] != SYS_SRET &&
						w[31:20] != SYS_MRET) begin
						bad = 1'b1;
					end
				end else begin
					fl[FL_RD] = 1'b1; fl[FL_CSR] = 1'b1; fl[FL_S2CSR] = 1'b1;
					if (f3 < 3'd5) begin
						fl[FL_RS1] = 1'b1;
					end
					unique case (f3)
						3'd1: alu = ALU_ADD;
						3'd2: alu = ALU_OR;
						3'd3: begin
							alu = ALU_AND; fl[FL_S1INV] = 1'b1;
						end
						3'd5: begin
							alu = ALU_ADD; fl[FL_S1RS1] = 1'b1;
						end
						3'd6: begin
							alu = ALU_OR; fl[FL_S1RS1] = 1'b1;
						end
						3'd7: begin
							alu = ALU_AND; fl[FL_S1INV] = 1'b1; fl[FL_S1RS1] = 1'b1;
						end
						default: bad = 1'b1;
					endcase
				end
			end
			OPC_FENCE: begin
				cls = CLS_FENCE;
			end
			default: begin
				bad = 1'b1;
			end
		endcase

		// register-register and register-immediate ALU ops
		if (opc == OPC_OP || opc == OPC_OPIMM) begin
			unique case (f3)
				3'd0: alu = (opc == OPC_OP && f7 != 7'd0) ? ALU_SUB : ALU_ADD;
				3'd1: alu = ALU_SLL;
				3'd2: alu = ALU_SLT;
				3'd3: alu = ALU_SLTU;
				3'd4: alu = ALU_XOR;
				3'd5: alu = (f7 != 7'd0) ? ALU_SRA : ALU_SRL;
				3'd6: alu = ALU_OR;
				3'd7: alu = ALU_AND;
			endcase
		end

		// writes to x0 are dropped
		if (rd == 5'd0) begin
			fl[FL_RD] = 1'b0;
		end
	end

	always_comb begin
		priority if (fl[FL_LOAD] || fl[FL_STORE]) begin
			unit = UNIT_LSU;
		end else if (fl[FL_CSR]) begin
			unit = UNIT_SFU;
		end else if (br != BR_NONE) begin
			unit = UNIT_BRU;
		end else begin
			unit = UNIT_ALU;
		end
	end

	always_comb begin
		rsp = '0;
		if (bad) begin
			rsp.illegal = 1'b1;
		end else begin
			rsp.opcode_class = cls;
			rsp.dest_reg     = rd;
			rsp.src1_reg     = rs1;
			rsp.src2_reg     = rs2;
			rsp.immediate    = imm;
			rsp.funct_bits   = {f7, f3};
			rsp.alu_sel      = alu;
			rsp.branch_sel   = br;
			rsp.unit_sel     = unit;
			rsp.ctrl_flags   = fl;
			rsp.pc_out       = cmd.pc;
		end
	end

endmodule

// ----- hw/rtl/rv32i_instruction_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_unit - RV32I instruction decoder
// Registers an instruction beat, decodes it and registers the result beat.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload        | direction
//  ---------+----------------------+----------------+----------
//  command  | start / busy         | cmd  (cmd_t)   | in
//  result   | done (1-cycle pulse) | rsp  (rsp_t)   | out
//
//  An accepted beat is captured in the input register, decoded
//  combinationally and captured in the result register, which drives rsp
//  with done high. One beat per cycle is sustained; busy is never raised,
//  since the decode path has no state and no shared unit.
//  Reset clears only the valid bits of both stages; payload registers are
//  not reset. The receiver cannot stall, so each result is shown exactly once.
//
module rv32i_instruction_decoder_unit
	import rv32id_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	// command channel
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	// result channel
	output logic done,
	output rsp_t rsp
);

	logic vld_s1;
	cmd_t cmd_s1;
	logic vld_s2;
	rsp_t rsp_s2;
	rsp_t dec_rsp;

	// never back-pressures
	assign busy = 1'b0;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	// input register: capture on an accepted beat
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	rv32id_decode u_decode (
		.cmd (cmd_s1),
		.rsp (dec_rsp)
	);

	// result register
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rsp_s2 <= dec_rsp;
		end
	end

	assign done = vld_s2;
	assign rsp  = rsp_s2;

endmodule
